// ===== hdl/drm_pkg.sv =====
package drm_pkg;

  // ring geometry
  localparam int RX_SLOTS     = 64;
  localparam int TX_SLOTS     = 32;
  localparam int BUFFER_BYTES = 2048;
  localparam int RX_SLOT_W    = $clog2(RX_SLOTS);
  localparam int TX_SLOT_W    = $clog2(TX_SLOTS);

  // field widths on the stream ports
  localparam int SLOT_OUT_W  = 6;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 176;

  // descriptor bits
  localparam logic [31:0] OWN_BIT      = 32'h8000_0000;
  localparam logic [31:0] EOR_BIT      = 32'h4000_0000;
  localparam logic [31:0] FS_BIT       = 32'h2000_0000;
  localparam logic [31:0] LS_BIT       = 32'h1000_0000;
  localparam logic [31:0] RX_LEN_MASK  = 32'h0000_3FFF;
  localparam logic [31:0] BUF_LEN_MASK = 32'h0000_1FFF;
  localparam logic [31:0] RX_ERRSUM    = 32'h0010_0000;

  // frame length limits
  localparam int MAX_FRAME  = 1518;
  localparam int MIN_RX_LEN = 18;
  localparam int MIN_TX_LEN = 60;
  localparam int FCS_BYTES  = 4;

  // interrupt status bits
  localparam logic [15:0] IRQ_RDU          = 16'h0010;
  localparam logic [15:0] IRQ_FOVW         = 16'h0040;
  localparam logic [15:0] IRQ_DRAIN_MASK   = 16'h0053;
  localparam logic [15:0] IRQ_RESTART_MASK = IRQ_RDU | IRQ_FOVW;

  // configuration register indexes
  localparam logic CFG_RX_BASE = 1'b0;
  localparam logic CFG_TX_BASE = 1'b1;

  typedef enum logic [1:0] {
    OP_RX   = 2'd0,
    OP_TX   = 2'd1,
    OP_IRQ  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    KIND_RX_EMPTY    = 4'd0,
    KIND_RX_ACCEPTED = 4'd1,
    KIND_RX_DROPPED  = 4'd2,
    KIND_TX_QUEUED   = 4'd3,
    KIND_TX_INVALID  = 4'd4,
    KIND_TX_TOO_BIG  = 4'd5,
    KIND_TX_BUSY     = 4'd6,
    KIND_IRQ_NOT_OURS = 4'd7,
    KIND_IRQ_HANDLED = 4'd8
  } kind_t;

  // one result beat, without the drop totals
  typedef struct packed {
    kind_t                   kind;
    logic [SLOT_OUT_W-1:0]   slot;
    logic [10:0]             dlen;
    logic [31:0]             desc;
    logic [31:0]             addr;
    logic [5:0]              pad;
    logic [15:0]             ack;
    logic                    drain;
    logic                    restart;
  } result_t;

endpackage

// ===== hdl/drm_rx_path.sv =====
module drm_rx_path (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  active,
  input  logic                  commit,
  input  logic [31:0]           status_word,
  input  logic [31:0]           buffer_base,
  output drm_pkg::result_t      res,
  output logic [31:0]           drop_total
);

  logic [drm_pkg::RX_SLOT_W-1:0] rx_slot;
  logic [drm_pkg::RX_SLOT_W-1:0] rx_slot_next;
  logic [31:0]                   rx_drop_count;
  logic [13:0]                   len;
  logic                          owned;
  logic                          frame_ok;
  logic                          last_slot;

  // classify the status word
  assign len      = 14'(status_word & drm_pkg::RX_LEN_MASK);
  assign owned    = (status_word & drm_pkg::OWN_BIT) != '0;
  assign frame_ok = ((status_word & (drm_pkg::FS_BIT | drm_pkg::LS_BIT)) ==
                     (drm_pkg::FS_BIT | drm_pkg::LS_BIT)) &&
                    (((status_word >> 1) & drm_pkg::RX_ERRSUM) == '0) &&
                    (len >= 14'(drm_pkg::MIN_RX_LEN)) &&
                    (len <= 14'(drm_pkg::MAX_FRAME + drm_pkg::FCS_BYTES));
  assign last_slot    = rx_slot == drm_pkg::RX_SLOT_W'(drm_pkg::RX_SLOTS - 1);
  assign rx_slot_next = last_slot ? '0 : rx_slot + 1'b1;

  // result fields
  always_comb begin
    res         = '0;
    res.slot    = drm_pkg::SLOT_OUT_W'(rx_slot);
    res.kind    = drm_pkg::KIND_RX_EMPTY;
    if (!owned) begin
      res.kind = frame_ok ? drm_pkg::KIND_RX_ACCEPTED : drm_pkg::KIND_RX_DROPPED;
      res.dlen = frame_ok ? 11'(len - 14'(drm_pkg::FCS_BYTES)) : '0;
      res.desc = drm_pkg::OWN_BIT | (last_slot ? drm_pkg::EOR_BIT : '0) |
                 (32'(drm_pkg::BUFFER_BYTES) & drm_pkg::BUF_LEN_MASK);
      res.addr = buffer_base + 32'(rx_slot) * 32'(drm_pkg::BUFFER_BYTES);
    end
  end

  // drop count as it stands after this beat
  assign drop_total = rx_drop_count + 32'(active && !owned && !frame_ok);

  // ring pointer and drop counter
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_slot       <= '0;
      rx_drop_count <= '0;
    end else if (commit && !owned) begin
      rx_slot       <= rx_slot_next;
      rx_drop_count <= drop_total;
    end
  end

endmodule

// ===== hdl/drm_tx_path.sv =====
module drm_tx_path (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  active,
  input  logic                  commit,
  input  logic [15:0]           tx_length,
  input  logic                  tx_frame_present,
  input  logic                  tx_slot_owned,
  input  logic [31:0]           buffer_base,
  output drm_pkg::result_t      res,
  output logic [31:0]           drop_total
);

  logic [drm_pkg::TX_SLOT_W-1:0] tx_slot;
  logic [drm_pkg::TX_SLOT_W-1:0] tx_slot_next;
  logic [31:0]                   tx_drop_count;
  logic                          invalid;
  logic                          too_big;
  logic                          short_frame;
  logic                          queued;
  logic                          last_slot;
  logic [15:0]                   xlen;

  // request checks, in priority order
  assign invalid     = !tx_frame_present || (tx_length == '0);
  assign too_big     = tx_length > 16'(drm_pkg::MAX_FRAME);
  assign queued      = !invalid && !too_big && !tx_slot_owned;
  assign short_frame = tx_length < 16'(drm_pkg::MIN_TX_LEN);
  assign xlen        = short_frame ? 16'(drm_pkg::MIN_TX_LEN) : tx_length;
  assign last_slot    = tx_slot == drm_pkg::TX_SLOT_W'(drm_pkg::TX_SLOTS - 1);
  assign tx_slot_next = last_slot ? '0 : tx_slot + 1'b1;

  // result fields
  always_comb begin
    res      = '0;
    res.slot = drm_pkg::SLOT_OUT_W'(tx_slot);
    if (invalid) begin
      res.kind = drm_pkg::KIND_TX_INVALID;
    end else if (too_big) begin
      res.kind = drm_pkg::KIND_TX_TOO_BIG;
    end else if (tx_slot_owned) begin
      res.kind = drm_pkg::KIND_TX_BUSY;
    end else begin
      res.kind = drm_pkg::KIND_TX_QUEUED;
      res.pad  = short_frame ? 6'(16'(drm_pkg::MIN_TX_LEN) - tx_length) : '0;
      res.desc = drm_pkg::OWN_BIT | drm_pkg::FS_BIT | drm_pkg::LS_BIT |
                 (last_slot ? drm_pkg::EOR_BIT : '0) |
                 (32'(xlen) & drm_pkg::BUF_LEN_MASK);
      res.addr = buffer_base + 32'(tx_slot) * 32'(drm_pkg::BUFFER_BYTES);
    end
  end

  // busy slot counts as a drop
  assign drop_total = tx_drop_count +
                      32'(active && !invalid && !too_big && tx_slot_owned);

  // ring pointer and drop counter
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_slot       <= '0;
      tx_drop_count <= '0;
    end else if (commit) begin
      tx_drop_count <= drop_total;
      if (queued) begin
        tx_slot <= tx_slot_next;
      end
    end
  end

endmodule

// ===== hdl/descriptor_ring_manager.sv =====
// an accepted beat is held in the input register, then loaded into the result register,
// which drives m_axis; loading waits while a held result has not been taken
// throughput: one beat per cycle while m_axis takes them, input and result stages both registered
// an operation code of three is consumed with no result beat
// reset (rst, synchronous) clears both ring slots, both drop counters,
// both buffer bases and all valid flags; no clearing pass is needed
module descriptor_ring_manager (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [31:0]                      cfg_data,
  // item stream in
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // rx_status_word, tx_length, tx_frame_present, tx_slot_owned, irq_status, zero fill
  input  logic [drm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // operation
  input  logic [1:0]                       s_axis_tuser,
  // result stream out
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // slot_index, deliver_length, descriptor_word, buffer_address, pad_bytes,
  // irq_ack, drain_rx, restart_rx, rx_drop_total, tx_drop_total, zero fill
  output logic [drm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // result_kind
  output logic [3:0]                       m_axis_tuser
);

  logic [31:0]        rx_buffer_base;
  logic [31:0]        tx_buffer_base;

  logic               in_valid;
  drm_pkg::op_t       in_op;
  logic [31:0]        in_word;
  logic [15:0]        in_tlen;
  logic               in_present;
  logic               in_owned;
  logic [15:0]        in_isr;

  logic               out_valid;
  drm_pkg::result_t   out_res;
  logic [31:0]        out_rx_total;
  logic [31:0]        out_tx_total;

  logic               load_out;
  logic               skip_beat;
  logic               advance;
  drm_pkg::result_t   rx_res;
  drm_pkg::result_t   tx_res;
  drm_pkg::result_t   irq_res;
  drm_pkg::result_t   sel_res;
  logic [31:0]        rx_drop_total;
  logic [31:0]        tx_drop_total;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_buffer_base <= '0;
      tx_buffer_base <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        drm_pkg::CFG_RX_BASE: rx_buffer_base <= cfg_data;
        drm_pkg::CFG_TX_BASE: tx_buffer_base <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage handshake
  assign load_out      = in_valid && (in_op != drm_pkg::OP_NONE) &&
                         (!out_valid || m_axis_tready);
  assign skip_beat     = in_valid && (in_op == drm_pkg::OP_NONE);
  assign advance       = load_out || skip_beat;
  assign s_axis_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op      <= drm_pkg::op_t'(s_axis_tuser);
      in_word    <= s_axis_tdata[31:0];
      in_tlen    <= s_axis_tdata[47:32];
      in_present <= s_axis_tdata[48];
      in_owned   <= s_axis_tdata[49];
      in_isr     <= s_axis_tdata[65:50];
    end
  end

  // receive ring
  drm_rx_path u_rx (
    .clk         (clk),
    .rst         (rst),
    .active      (in_op == drm_pkg::OP_RX),
    .commit      (load_out && (in_op == drm_pkg::OP_RX)),
    .status_word (in_word),
    .buffer_base (rx_buffer_base),
    .res         (rx_res),
    .drop_total  (rx_drop_total)
  );

  // transmit ring
  drm_tx_path u_tx (
    .clk              (clk),
    .rst              (rst),
    .active           (in_op == drm_pkg::OP_TX),
    .commit           (load_out && (in_op == drm_pkg::OP_TX)),
    .tx_length        (in_tlen),
    .tx_frame_present (in_present),
    .tx_slot_owned    (in_owned),
    .buffer_base      (tx_buffer_base),
    .res              (tx_res),
    .drop_total       (tx_drop_total)
  );

  // interrupt decode
  always_comb begin
    irq_res      = '0;
    irq_res.kind = drm_pkg::KIND_IRQ_NOT_OURS;
    if (in_isr != '0) begin
      irq_res.kind    = drm_pkg::KIND_IRQ_HANDLED;
      irq_res.ack     = in_isr;
      irq_res.drain   = (in_isr & drm_pkg::IRQ_DRAIN_MASK) != '0;
      irq_res.restart = (in_isr & drm_pkg::IRQ_RESTART_MASK) != '0;
    end
  end

  // pick the result by operation
  always_comb begin
    case (in_op)
      drm_pkg::OP_RX:  sel_res = rx_res;
      drm_pkg::OP_TX:  sel_res = tx_res;
      drm_pkg::OP_IRQ: sel_res = irq_res;
      default:         sel_res = irq_res;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res      <= sel_res;
      out_rx_total <= rx_drop_total;
      out_tx_total <= tx_drop_total;
    end
  end

  // output beat
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.kind;
  assign m_axis_tdata  = {7'b0, out_tx_total, out_rx_total, out_res.restart,
                          out_res.drain, out_res.ack, out_res.pad, out_res.addr,
                          out_res.desc, out_res.dlen, out_res.slot};

`ifndef SYNTHESIS
  // input stage only blocks when it holds a beat that cannot move on
  a_ready_block: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (in_valid && !advance))
    else $error("input stall without a pending beat");

  // an accepted rx frame always hands the slot back with a real length
  a_rx_accept: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (out_res.kind == drm_pkg::KIND_RX_ACCEPTED)) |->
    (((out_res.desc & drm_pkg::OWN_BIT) != '0) && (out_res.dlen >= 11'd14)))
    else $error("rx accept without ownership or with short length");

  // interrupt beats carry slot zero and leave the rx drop total alone
  a_irq_counts: assert property (@(posedge clk) disable iff (rst)
    (load_out && (in_op == drm_pkg::OP_IRQ)) |=>
    ((out_res.slot == '0) && (out_rx_total == $past(rx_drop_total))))
    else $error("irq result disturbed slot or rx drop total");

  // a skipped beat never produces a result
  a_skip_quiet: assert property (@(posedge clk) disable iff (rst)
    (skip_beat && !out_valid) |=> !out_valid)
    else $error("result produced for an ignored operation");
`endif

endmodule

// ===== test/descriptor_ring_manager_test.sv =====
`timescale 1ns / 1ps

module descriptor_ring_manager_test;
  import drm_pkg::*;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int PHASE_ITEMS  = 110;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT_BEAT = 120;

  // input beat layout, first member in the highest bits
  typedef struct packed {
    logic [5:0]  fill;
    logic [15:0] isr;
    logic        owned;
    logic        present;
    logic [15:0] tlen;
    logic [31:0] word;
  } in_data_t;

  // result beat layout, first member in the highest bits
  typedef struct packed {
    logic [6:0]  fill;
    logic [31:0] tx_drops;
    logic [31:0] rx_drops;
    logic        restart;
    logic        drain;
    logic [15:0] ack;
    logic [5:0]  pad;
    logic [31:0] addr;
    logic [31:0] desc;
    logic [10:0] dlen;
    logic [5:0]  slot;
  } out_data_t;

  typedef struct packed {
    op_t      op;
    in_data_t data;
  } ring_item_t;

  typedef struct packed {
    kind_t     kind;
    out_data_t data;
  } ring_beat_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic                   cfg_index;
  logic [31:0]            cfg_data;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // rx_status_word, tx_length, tx_frame_present, tx_slot_owned, irq_status, zero fill
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  // operation
  logic [1:0]             s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // slot_index, deliver_length, descriptor_word, buffer_address, pad_bytes,
  // irq_ack, drain_rx, restart_rx, rx_drop_total, tx_drop_total, zero fill
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // result_kind
  logic [3:0]             m_axis_tuser;

  // ring state mirrored by the predictor
  logic [5:0]  rx_ptr = '0;
  logic [4:0]  tx_ptr = '0;
  logic [31:0] rx_drop_cnt = '0;
  logic [31:0] tx_drop_cnt = '0;
  logic [31:0] rx_base = '0;
  logic [31:0] tx_base = '0;

  ring_beat_t awaited_beats[$];
  int         error_count = 0;
  int         beats_seen = 0;
  int         cycle_count = 0;
  bit         quiet = 1'b0;

  descriptor_ring_manager i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // classify one item against the mirrored ring, returns 0 when no beat follows
  function automatic bit classify_item(input ring_item_t it, output ring_beat_t b);
    logic [13:0] len;
    logic [15:0] xlen;
    b = '0;
    if (it.op == OP_NONE) return 1'b0;
    case (it.op)
      OP_RX: begin
        b.data.slot = rx_ptr;
        if ((it.data.word & OWN_BIT) != '0) begin
          b.kind = KIND_RX_EMPTY;
        end else begin
          len = it.data.word[13:0];
          if ((it.data.word & (FS_BIT | LS_BIT)) == (FS_BIT | LS_BIT) &&
              ((it.data.word >> 1) & RX_ERRSUM) == '0 &&
              len >= MIN_RX_LEN && len <= MAX_FRAME + FCS_BYTES) begin
            b.kind = KIND_RX_ACCEPTED;
            b.data.dlen = 11'(len - FCS_BYTES);
          end else begin
            b.kind = KIND_RX_DROPPED;
            rx_drop_cnt = rx_drop_cnt + 1;
          end
          b.data.desc = OWN_BIT | ((rx_ptr == RX_SLOTS - 1) ? EOR_BIT : 32'h0) |
                        (32'(BUFFER_BYTES) & BUF_LEN_MASK);
          b.data.addr = rx_base + 32'(rx_ptr) * 32'(BUFFER_BYTES);
          rx_ptr = rx_ptr + 1'b1;
        end
      end
      OP_TX: begin
        b.data.slot = {1'b0, tx_ptr};
        if (!it.data.present || it.data.tlen == '0) begin
          b.kind = KIND_TX_INVALID;
        end else if (it.data.tlen > MAX_FRAME) begin
          b.kind = KIND_TX_TOO_BIG;
        end else if (it.data.owned) begin
          b.kind = KIND_TX_BUSY;
          tx_drop_cnt = tx_drop_cnt + 1;
        end else begin
          xlen = it.data.tlen;
          if (xlen < MIN_TX_LEN) begin
            b.data.pad = 6'(MIN_TX_LEN - xlen);
            xlen = 16'(MIN_TX_LEN);
          end
          b.kind = KIND_TX_QUEUED;
          b.data.desc = OWN_BIT | FS_BIT | LS_BIT |
                        ((tx_ptr == TX_SLOTS - 1) ? EOR_BIT : 32'h0) |
                        (32'(xlen) & BUF_LEN_MASK);
          b.data.addr = tx_base + 32'(tx_ptr) * 32'(BUFFER_BYTES);
          tx_ptr = tx_ptr + 1'b1;
        end
      end
      default: begin
        if (it.data.isr == '0) begin
          b.kind = KIND_IRQ_NOT_OURS;
        end else begin
          b.kind = KIND_IRQ_HANDLED;
          b.data.ack = it.data.isr;
          b.data.drain = |(it.data.isr & IRQ_DRAIN_MASK);
          b.data.restart = |(it.data.isr & IRQ_RESTART_MASK);
        end
      end
    endcase
    b.data.rx_drops = rx_drop_cnt;
    b.data.tx_drops = tx_drop_cnt;
    return 1'b1;
  endfunction

  function automatic ring_item_t make_item(input op_t op, input logic [31:0] word,
                                           input logic [15:0] tlen, input logic present,
                                           input logic owned, input logic [15:0] isr);
    ring_item_t it;
    it = '0;
    it.op = op;
    it.data.word = word;
    it.data.tlen = tlen;
    it.data.present = present;
    it.data.owned = owned;
    it.data.isr = isr;
    return it;
  endfunction

  // a beat from reset state whose fields are all zero but these
  function automatic ring_beat_t known_beat(input kind_t kind, input logic [15:0] ack,
                                            input logic drain, input logic restart);
    ring_beat_t b;
    b = '0;
    b.kind = kind;
    b.data.ack = ack;
    b.data.drain = drain;
    b.data.restart = restart;
    return b;
  endfunction

  // random item, mostly well-formed frames and requests with random content
  function automatic ring_item_t random_item();
    ring_item_t it;
    int         pick;
    int         choose;
    it.data = IN_TDATA_W'({$urandom, $urandom, $urandom});
    it.data.fill = '0;
    pick = $urandom_range(0, 99);
    choose = $urandom_range(0, 9);
    if (pick < 4) begin
      it.op = OP_NONE;
    end else if (pick < 44) begin
      it.op = OP_RX;
      if (choose < 6) begin
        it.data.word = (it.data.word & ~(OWN_BIT | (RX_ERRSUM << 1) | RX_LEN_MASK)) |
                       FS_BIT | LS_BIT | 32'($urandom_range(MIN_RX_LEN, MAX_FRAME + FCS_BYTES));
      end else if (choose < 8) begin
        it.data.word = it.data.word | OWN_BIT;
      end
    end else if (pick < 76) begin
      it.op = OP_TX;
      if (choose < 7) it.data.tlen = 16'($urandom_range(1, MAX_FRAME));
      else if (choose < 8) it.data.tlen = 16'($urandom_range(1, MIN_TX_LEN - 1));
      else if (choose < 9) it.data.tlen = '0;
      it.data.present = ($urandom_range(0, 19) != 0);
      it.data.owned = ($urandom_range(0, 6) == 0);
    end else begin
      it.op = OP_IRQ;
      if (choose == 0) it.data.isr = '0;
      else if (choose < 4) it.data.isr = 16'(1) << $urandom_range(0, 15);
    end
    return it;
  endfunction

  task automatic report_error(input string msg);
    $display("error at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("beat %0d %s got %h want %h", beats_seen, name, got, want));
  endtask

  task automatic check_beat(input kind_t got_kind, input out_data_t got);
    ring_beat_t want;
    beats_seen++;
    if (awaited_beats.size() == 0) begin
      report_error($sformatf("beat %0d arrived with none expected", beats_seen));
      return;
    end
    want = awaited_beats.pop_front();
    check_field("result_kind", 32'(got_kind), 32'(want.kind));
    check_field("slot_index", 32'(got.slot), 32'(want.data.slot));
    check_field("deliver_length", 32'(got.dlen), 32'(want.data.dlen));
    check_field("descriptor_word", got.desc, want.data.desc);
    check_field("buffer_address", got.addr, want.data.addr);
    check_field("pad_bytes", 32'(got.pad), 32'(want.data.pad));
    check_field("irq_ack", 32'(got.ack), 32'(want.data.ack));
    check_field("drain_rx", 32'(got.drain), 32'(want.data.drain));
    check_field("restart_rx", 32'(got.restart), 32'(want.data.restart));
    check_field("rx_drop_total", got.rx_drops, want.data.rx_drops);
    check_field("tx_drop_total", got.tx_drops, want.data.tx_drops);
    check_field("zero fill", 32'(got.fill), '0);
  endtask

  // offer one item, entered and left at a falling edge
  task automatic send_item(input ring_item_t it, input bit typed, input ring_beat_t want);
    ring_beat_t pred;
    bit         has_beat;
    if (!quiet && $urandom_range(0, 99) < 12) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = it.data;
    s_axis_tuser = it.op;
    do @(posedge clk); while (!s_axis_tready);
    has_beat = classify_item(it, pred);
    if (has_beat) awaited_beats.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  // let every awaited beat arrive, then let the block settle with no input
  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (awaited_beats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic index, input logic [31:0] value);
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (index == CFG_RX_BASE) rx_base = value;
    else tx_base = value;
  endtask

  // result side: random stalls, one long hold-off to back up the block
  initial begin
    int  stall_left;
    bit  held;
    stall_left = 0;
    held = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) stall_left--;
      else if (!quiet && $urandom_range(0, 99) < 8) stall_left = $urandom_range(1, 19);
      if (!held && beats_seen >= HOLD_AT_BEAT) begin
        held = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      m_axis_tready = (stall_left == 0) && !rst;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      check_beat(kind_t'(m_axis_tuser), out_data_t'(m_axis_tdata));
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // stimulus
  initial begin
    ring_item_t dir_items[$];
    bit         dir_typed[$];
    ring_beat_t dir_want[$];
    ring_item_t it;
    ring_beat_t no_beat;
    logic [31:0] rxb;
    logic [31:0] txb;
    int         n;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_RX_BASE;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_NONE;
    no_beat = '0;

    // directed table: rows with a typed result leave the ring state untouched
    dir_items.push_back(make_item(OP_RX, OWN_BIT | FS_BIT | LS_BIT | 32'd64, 0, 0, 0, 0));
    dir_typed.push_back(1);
    dir_want.push_back(known_beat(KIND_RX_EMPTY, 0, 0, 0));
    dir_items.push_back(make_item(OP_TX, 0, 16'd100, 1'b0, 1'b0, 0));
    dir_typed.push_back(1);
    dir_want.push_back(known_beat(KIND_TX_INVALID, 0, 0, 0));
    dir_items.push_back(make_item(OP_TX, 0, 16'd0, 1'b1, 1'b1, 0));
    dir_typed.push_back(1);
    dir_want.push_back(known_beat(KIND_TX_INVALID, 0, 0, 0));
    dir_items.push_back(make_item(OP_TX, 0, 16'd1519, 1'b1, 1'b0, 0));
    dir_typed.push_back(1);
    dir_want.push_back(known_beat(KIND_TX_TOO_BIG, 0, 0, 0));
    dir_items.push_back(make_item(OP_TX, '1, 16'hFFFF, 1'b1, 1'b1, '1));
    dir_typed.push_back(1);
    dir_want.push_back(known_beat(KIND_TX_TOO_BIG, 0, 0, 0));
    dir_items.push_back(make_item(OP_IRQ, '1, '1, 1'b1, 1'b1, 16'h0000));
    dir_typed.push_back(1);
    dir_want.push_back(known_beat(KIND_IRQ_NOT_OURS, 0, 0, 0));
    dir_items.push_back(make_item(OP_IRQ, 0, 0, 0, 0, 16'hFFFF));
    dir_typed.push_back(1);
    dir_want.push_back(known_beat(KIND_IRQ_HANDLED, 16'hFFFF, 1'b1, 1'b1));
    dir_items.push_back(make_item(OP_NONE, '1, '1, 1'b1, 1'b1, '1));
    dir_typed.push_back(0);
    dir_want.push_back(no_beat);

    // frame length limits, flag and error summary cases
    dir_items.push_back(make_item(OP_RX, FS_BIT | LS_BIT | 32'd18, 0, 0, 0, 0));
    dir_items.push_back(make_item(OP_RX, FS_BIT | LS_BIT | 32'd1522, 0, 0, 0, 0));
    dir_items.push_back(make_item(OP_RX, FS_BIT | LS_BIT | 32'd17, 0, 0, 0, 0));
    dir_items.push_back(make_item(OP_RX, FS_BIT | LS_BIT | 32'd1523, 0, 0, 0, 0));
    dir_items.push_back(make_item(OP_RX, LS_BIT | 32'd64, 0, 0, 0, 0));
    dir_items.push_back(make_item(OP_RX, FS_BIT | 32'd64, 0, 0, 0, 0));
    dir_items.push_back(make_item(OP_RX, FS_BIT | LS_BIT | (RX_ERRSUM << 1) | 32'd64,
                                  0, 0, 0, 0));
    dir_items.push_back(make_item(OP_RX, FS_BIT | LS_BIT | RX_LEN_MASK, 0, 0, 0, 0));
    dir_items.push_back(make_item(OP_RX, 32'h7FFF_FFFF, 0, 0, 0, 0));
    // padding and length edges on transmit, then a busy slot
    dir_items.push_back(make_item(OP_TX, 0, 16'd1, 1'b1, 1'b0, 0));
    dir_items.push_back(make_item(OP_TX, 0, 16'd59, 1'b1, 1'b0, 0));
    dir_items.push_back(make_item(OP_TX, 0, 16'd60, 1'b1, 1'b0, 0));
    dir_items.push_back(make_item(OP_TX, 0, 16'd1518, 1'b1, 1'b0, 0));
    dir_items.push_back(make_item(OP_TX, 0, 16'd100, 1'b1, 1'b1, 0));
    // single interrupt status bits on their own
    dir_items.push_back(make_item(OP_IRQ, 0, 0, 0, 0, 16'h0001));
    dir_items.push_back(make_item(OP_IRQ, 0, 0, 0, 0, IRQ_RDU));
    dir_items.push_back(make_item(OP_IRQ, 0, 0, 0, 0, IRQ_FOVW));
    dir_items.push_back(make_item(OP_IRQ, 0, 0, 0, 0, 16'h0100));
    while (dir_typed.size() < dir_items.size()) begin
      dir_typed.push_back(0);
      dir_want.push_back(no_beat);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < dir_items.size(); i++)
      send_item(dir_items[i], dir_typed[i], dir_want[i]);

    // random phases, each under a fresh pair of buffer bases
    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          rxb = '1;
          txb = '1;
        end
        1: begin
          rxb = $urandom;
          txb = $urandom;
        end
        2: begin
          rxb = '0;
          txb = 32'h8000_0000;
        end
        default: begin
          rxb = $urandom;
          txb = '0;
          quiet = 1'b1;
        end
      endcase
      write_reg(CFG_RX_BASE, rxb);
      write_reg(CFG_TX_BASE, txb);
      n = 0;
      while (n < PHASE_ITEMS) begin
        it = random_item();
        send_item(it, 0, no_beat);
        if (it.op != OP_NONE) n++;
      end
    end

    wait_idle();
    if (error_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/drm_pkg.sv
hdl/drm_rx_path.sv
hdl/drm_tx_path.sv
hdl/descriptor_ring_manager.sv
test/descriptor_ring_manager_test.sv
